[sv/afs_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afs_pkg
// Shared types and constants of the start-code frame splitter.
// ---------------------------------------------------------------------------
package afs_pkg;

	localparam int BYTE_W       = 8;
	localparam int TYPE_W       = 5;
	localparam int LEN_W        = 24;
	localparam int ZCNT_W       = 2;
	localparam int CFG_IDX_W    = 1;
	localparam int COUNT_W_DEF  = 24;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [ZCNT_W-1:0] ZCNT_MAX = 2'd3;
	localparam logic [TYPE_W-1:0] MIN_TYPE_RST = 5'd1;
	localparam logic [TYPE_W-1:0] MAX_TYPE_RST = 5'd6;
	localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
	localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TYPE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TYPE = 1'd1;

	// one classified request: held zeros to emit, then an optional byte,
	// then an optional frame end
	typedef struct packed {
		logic              has_end;
		logic              has_byte;
		logic [BYTE_W-1:0] data;
		logic [ZCNT_W-1:0] zeros;
	} cmd_t;

endpackage

[sv/afs_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afs_front
// Accepts stream bytes, tracks held zeros and unit type, classifies each
// byte and pushes an emit request for the back end when it yields one.
// ---------------------------------------------------------------------------
module afs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [afs_pkg::BYTE_W-1:0]    s_axis_tdata,   // data_byte
	input  logic                          s_axis_tlast,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [afs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [afs_pkg::TYPE_W-1:0]    cfg_data,
	input  logic                          q_ready,
	output logic                          q_push,
	output afs_pkg::cmd_t                 q_cmd
);
	import afs_pkg::*;

	logic [TYPE_W-1:0] min_type_q;
	logic [TYPE_W-1:0] max_type_q;
	logic [ZCNT_W-1:0] held_q;
	logic              captured_q;
	logic [TYPE_W-1:0] unit_type_q;

	logic              accept;
	logic [TYPE_W-1:0] cur_type;
	logic              in_range;
	logic [ZCNT_W-1:0] held_d;
	logic              captured_d;
	logic [TYPE_W-1:0] unit_type_d;
	cmd_t              cmd;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = q_ready;
	assign accept        = s_axis_tvalid & s_axis_tready;

	assign cur_type = captured_q ? unit_type_q : s_axis_tdata[TYPE_W-1:0];
	assign in_range = (cur_type >= min_type_q) && (cur_type <= max_type_q);

	always_comb begin
		cmd         = '0;
		held_d      = held_q;
		captured_d  = 1'b1;
		unit_type_d = cur_type;
		if (s_axis_tlast) begin
			cmd.zeros   = held_q;
			cmd.has_end = 1'b1;
			held_d      = '0;
			captured_d  = 1'b0;
			unit_type_d = '0;
		end else if (s_axis_tdata == BYTE_ZERO) begin
			if (held_q != ZCNT_MAX) begin
				held_d = held_q + 1'b1;
			end else begin
				cmd.has_byte = 1'b1;
				cmd.data     = BYTE_ZERO;
			end
		end else if (s_axis_tdata == BYTE_ONE && held_q == ZCNT_MAX) begin
			held_d      = '0;
			cmd.has_end = in_range;
			captured_d  = 1'b0;
			unit_type_d = '0;
		end else begin
			cmd.zeros    = held_q;
			cmd.has_byte = 1'b1;
			cmd.data     = s_axis_tdata;
			held_d       = '0;
		end
	end

	assign q_cmd  = cmd;
	assign q_push = accept & (cmd.has_end | cmd.has_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_type_q  <= MIN_TYPE_RST;
			max_type_q  <= MAX_TYPE_RST;
			held_q      <= '0;
			captured_q  <= 1'b0;
			unit_type_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MIN_TYPE: min_type_q <= cfg_data;
					CFG_MAX_TYPE: max_type_q <= cfg_data;
					default:      min_type_q <= min_type_q;
				endcase
			end
			if (accept) begin
				held_q      <= held_d;
				captured_q  <= captured_d;
				unit_type_q <= unit_type_d;
			end
		end
	end

endmodule

[sv/afs_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afs_queue
// Small request queue between the classifier and the result generator.
// ---------------------------------------------------------------------------
module afs_queue #(
	parameter int DEPTH = afs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  afs_pkg::cmd_t push_cmd,
	output logic          ready,
	input  logic          pop,
	output logic          valid,
	output afs_pkg::cmd_t head
);
	import afs_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	assign ready = (cnt_q != CW'(DEPTH));
	assign valid = (cnt_q != '0);
	assign head  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count above depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> ready)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid)
		else $error("pop from empty queue");
`endif

endmodule

[sv/afs_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// afs_back
// Expands queued requests into result items one per cycle while the output
// is not stalled and keeps the saturating frame byte count.
// ---------------------------------------------------------------------------
module afs_back #(
	parameter int COUNT_WIDTH = afs_pkg::COUNT_W_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     q_valid,
	input  afs_pkg::cmd_t                            q_head,
	output logic                                     q_pop,
	output logic                                     m_axis_tvalid,
	input  logic                                     m_axis_tready,
	output logic [afs_pkg::BYTE_W+afs_pkg::LEN_W-1:0] m_axis_tdata,
	output logic                                     m_axis_tlast,
	output logic [0:0]                               m_axis_tuser
);
	import afs_pkg::*;

	logic              cur_valid_q;
	cmd_t              cur_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_bv_q;
	logic              out_end_q;
	logic [LEN_W-1:0]  out_len_q;

	logic              load;
	logic              fire;
	logic              emit_zero;
	logic              emit_byte;
	logic              last;
	logic              empty_next;
	logic [LEN_W-1:0]  len;

	generate
		if (COUNT_WIDTH > LEN_W) begin : g_len_sat
			assign len = (|cnt_q[COUNT_WIDTH-1:LEN_W]) ? '1 : cnt_q[LEN_W-1:0];
		end else begin : g_len_ext
			assign len = LEN_W'(cnt_q);
		end
	endgenerate

	assign load      = !out_valid_q || m_axis_tready;
	assign fire      = load && cur_valid_q;
	assign emit_zero = (cur_q.zeros != '0);
	assign emit_byte = !emit_zero && cur_q.has_byte;

	always_comb begin
		if (emit_zero) begin
			last = !cur_q.has_byte && !cur_q.has_end && (cur_q.zeros == 2'd1);
		end else if (emit_byte) begin
			last = !cur_q.has_end;
		end else begin
			last = 1'b1;
		end
	end

	assign empty_next = !cur_valid_q || (fire && last);
	assign q_pop      = empty_next && q_valid;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_head;
		end else if (fire) begin
			if (emit_zero) begin
				cur_q.zeros <= cur_q.zeros - 1'b1;
			end else if (emit_byte) begin
				cur_q.has_byte <= 1'b0;
			end
		end
		if (fire) begin
			out_byte_q <= emit_zero ? BYTE_ZERO : (emit_byte ? cur_q.data : BYTE_ZERO);
			out_bv_q   <= emit_zero || emit_byte;
			out_end_q  <= !emit_zero && !emit_byte;
			out_len_q  <= (emit_zero || emit_byte) ? '0 : len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (q_pop) begin
				cur_valid_q <= 1'b1;
			end else if (fire && last) begin
				cur_valid_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= fire;
			end
			if (fire) begin
				if (emit_zero || emit_byte) begin
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end else begin
					cnt_q <= '0;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_len_q, out_byte_q};
	assign m_axis_tlast  = out_end_q;
	assign m_axis_tuser  = out_bv_q;

`ifndef NO_ASSERTIONS
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_bv_q != out_end_q))
		else $error("result is neither or both byte and frame end");
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_end_q) |-> (out_byte_q == BYTE_ZERO))
		else $error("frame end carries a byte");
	a_cur_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_q.zeros != '0 || cur_q.has_byte || cur_q.has_end))
		else $error("empty request in result generator");
	a_cnt_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !emit_zero && !emit_byte) |=> (cnt_q == '0))
		else $error("byte count not cleared at frame end");
`endif

endmodule

[sv/annexb_frame_splitter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// annexb_frame_splitter
// Strips 00 00 00 01 start codes from a byte stream and marks frame ends.
// ---------------------------------------------------------------------------
// Input bytes are taken at one per cycle while the four-entry request queue
// has room. Each byte turns into zero to four results (held zeros, the byte,
// a frame end), and the result generator puts out one result per cycle
// while the output is not stalled. A start code that closes no frame and a
// held zero produce no result. tlast on input flushes the held zeros and
// always closes the frame; tlast on output marks a frame-end result carrying
// the saturated byte count.
module annexb_frame_splitter #(
	parameter int COUNT_WIDTH = afs_pkg::COUNT_W_DEF,
	parameter int QUEUE_DEPTH = afs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_axis_tvalid,
	output logic                                      s_axis_tready,
	input  logic [afs_pkg::BYTE_W-1:0]                s_axis_tdata,  // data_byte
	input  logic                                      s_axis_tlast,  // end_of_input
	output logic                                      m_axis_tvalid,
	input  logic                                      m_axis_tready,
	output logic [afs_pkg::BYTE_W+afs_pkg::LEN_W-1:0] m_axis_tdata,  // out_byte, frame_len
	output logic                                      m_axis_tlast,  // frame_end
	output logic [0:0]                                m_axis_tuser,  // byte_valid
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [afs_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [afs_pkg::TYPE_W-1:0]                cfg_data
);
	import afs_pkg::*;

	logic q_ready;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	logic q_valid;
	cmd_t q_head;

	afs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.q_ready       (q_ready),
		.q_push        (q_push),
		.q_cmd         (q_cmd)
	);

	afs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.ready    (q_ready),
		.pop      (q_pop),
		.valid    (q_valid),
		.head     (q_head)
	);

	afs_back #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

endmodule

[test/tb_annexb_frame_splitter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_annexb_frame_splitter
// Self-checking stream test of the start-code frame splitter.
// ---------------------------------------------------------------------------
// A scoreboard mirrors the splitter: it holds back zero runs, drops
// 00 00 00 01 start codes, captures the unit type from the first byte of
// each unit and predicts a frame-end result with the byte count whenever a
// unit in the configured type range closes. Directed bytes hit the start
// code corner cases, then random units, broken start codes and noise run
// under several type ranges and several sender and receiver idle patterns.
// ---------------------------------------------------------------------------

typedef struct packed {
	logic [afs_pkg::BYTE_W-1:0] out_byte;
	logic                       byte_valid;
	logic                       frame_end;
	logic [afs_pkg::LEN_W-1:0]  frame_len;
} split_result_t;

class frame_scoreboard;
	split_result_t              expected_q[$];
	logic [afs_pkg::TYPE_W-1:0] min_type;
	logic [afs_pkg::TYPE_W-1:0] max_type;
	logic [afs_pkg::ZCNT_W-1:0] held_zeros;
	bit                         header_seen;
	logic [afs_pkg::TYPE_W-1:0] cur_type;
	logic [afs_pkg::LEN_W-1:0]  byte_count;
	int                         errors;
	int                         results_seen;
	int                         frames_seen;

	function new();
		min_type     = afs_pkg::MIN_TYPE_RST;
		max_type     = afs_pkg::MAX_TYPE_RST;
		held_zeros   = '0;
		header_seen  = 0;
		cur_type     = '0;
		byte_count   = '0;
		errors       = 0;
		results_seen = 0;
		frames_seen  = 0;
	endfunction

	function void write_reg(logic [afs_pkg::CFG_IDX_W-1:0] idx,
			logic [afs_pkg::TYPE_W-1:0] val);
		if (idx == afs_pkg::CFG_MIN_TYPE)
			min_type = val;
		else if (idx == afs_pkg::CFG_MAX_TYPE)
			max_type = val;
	endfunction

	function void push_byte(logic [afs_pkg::BYTE_W-1:0] b);
		split_result_t r;
		r.out_byte   = b;
		r.byte_valid = 1'b1;
		r.frame_end  = 1'b0;
		r.frame_len  = '0;
		expected_q.push_back(r);
		if (byte_count != '1)
			byte_count++;
	endfunction

	function void push_frame_end();
		split_result_t r;
		r.out_byte   = '0;
		r.byte_valid = 1'b0;
		r.frame_end  = 1'b1;
		r.frame_len  = byte_count;
		expected_q.push_back(r);
		byte_count = '0;
	endfunction

	function void release_zeros();
		int i;
		for (i = 0; i < held_zeros; i++)
			push_byte(afs_pkg::BYTE_ZERO);
		held_zeros = '0;
	endfunction

	function void note_input(logic [afs_pkg::BYTE_W-1:0] b, logic last);
		if (last) begin
			release_zeros();
			push_frame_end();
			header_seen = 0;
			cur_type    = '0;
			return;
		end
		if (!header_seen) begin
			cur_type    = b[afs_pkg::TYPE_W-1:0];
			header_seen = 1;
		end
		if (b == afs_pkg::BYTE_ZERO) begin
			if (held_zeros != afs_pkg::ZCNT_MAX)
				held_zeros++;
			else
				push_byte(afs_pkg::BYTE_ZERO);
		end else if (b == afs_pkg::BYTE_ONE && held_zeros == afs_pkg::ZCNT_MAX) begin
			held_zeros = '0;
			if (cur_type >= min_type && cur_type <= max_type)
				push_frame_end();
			header_seen = 0;
			cur_type    = '0;
		end else begin
			release_zeros();
			push_byte(b);
		end
	endfunction

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
		errors++;
	endtask

	task check_result(logic [afs_pkg::BYTE_W+afs_pkg::LEN_W-1:0] tdata, logic tlast,
			logic tuser);
		split_result_t want;
		if (expected_q.size() == 0) begin
			report_mismatch("unexpected result tdata", 32'(tdata), 0);
			return;
		end
		want = expected_q.pop_front();
		results_seen++;
		if (tlast)
			frames_seen++;
		if (tdata[afs_pkg::BYTE_W-1:0] != want.out_byte)
			report_mismatch("out_byte", 32'(tdata[afs_pkg::BYTE_W-1:0]),
				32'(want.out_byte));
		if (tuser != want.byte_valid)
			report_mismatch("byte_valid", 32'(tuser), 32'(want.byte_valid));
		if (tlast != want.frame_end)
			report_mismatch("frame_end", 32'(tlast), 32'(want.frame_end));
		if (tdata[afs_pkg::BYTE_W+:afs_pkg::LEN_W] != want.frame_len)
			report_mismatch("frame length", 32'(tdata[afs_pkg::BYTE_W+:afs_pkg::LEN_W]),
				32'(want.frame_len));
	endtask

	function int pending();
		return expected_q.size();
	endfunction
endclass

module tb_annexb_frame_splitter;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASES        = 6;
	localparam int PHASE_ITEMS   = 42;

	logic                                      clk;
	logic                                      arst_n;
	logic                                      s_axis_tvalid;
	logic                                      s_axis_tready;
	logic [afs_pkg::BYTE_W-1:0]                s_axis_tdata;
	logic                                      s_axis_tlast;
	logic                                      m_axis_tvalid;
	logic                                      m_axis_tready;
	logic [afs_pkg::BYTE_W+afs_pkg::LEN_W-1:0] m_axis_tdata;
	logic                                      m_axis_tlast;
	logic [0:0]                                m_axis_tuser;
	logic                                      cfg_valid;
	logic                                      cfg_ready;
	logic [afs_pkg::CFG_IDX_W-1:0]             cfg_index;
	logic [afs_pkg::TYPE_W-1:0]                cfg_data;

	frame_scoreboard sb;
	int              send_idle_pct;
	int              recv_stall_pct;
	int              hold_left;
	int              items_sent;
	int              cfg_writes;

	annexb_frame_splitter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#3ms;
		$display("[annexb_frame_splitter] ERROR");
		$finish;
	end

	// receiver side: a long hold-off when one is set, else random stalls
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
	end

	task automatic send_item(logic [afs_pkg::BYTE_W-1:0] b, logic last);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = b;
		s_axis_tlast  = last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_input(b, last);
		items_sent++;
	endtask

	task automatic drain_stream();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [afs_pkg::CFG_IDX_W-1:0] idx,
			logic [afs_pkg::TYPE_W-1:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_start_code();
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(afs_pkg::BYTE_ONE, 1'b0);
	endtask

	// one unit: header, payload with zero runs, then a closing pattern; or a short noise burst
	task automatic send_unit();
		logic [afs_pkg::BYTE_W-1:0] b;
		logic [afs_pkg::TYPE_W-1:0] t;
		int                         n;
		int                         i;
		int                         pick;
		pick = $urandom_range(99);
		if (pick < 10) begin
			n = $urandom_range(3, 8);
			for (i = 0; i < n; i++) begin
				b = ($urandom_range(2) == 0) ? afs_pkg::BYTE_ZERO : 8'($urandom);
				send_item(b, $urandom_range(19) == 0);
			end
			return;
		end
		t = 5'($urandom);
		if ($urandom_range(1) == 0 && sb.min_type <= sb.max_type)
			t = 5'($urandom_range(sb.max_type, sb.min_type));
		b = 8'($urandom);
		b[afs_pkg::TYPE_W-1:0] = t;
		send_item(b, 1'b0);
		n = $urandom_range(0, 7);
		for (i = 0; i < n; i++) begin
			b = ($urandom_range(3) == 0) ? afs_pkg::BYTE_ZERO : 8'($urandom);
			send_item(b, 1'b0);
		end
		pick = $urandom_range(99);
		if (pick < 60) begin
			send_start_code();
		end else if (pick < 70) begin
			send_item(8'($urandom), 1'b1);
		end else if (pick < 80) begin
			send_item(afs_pkg::BYTE_ZERO, 1'b0);
			send_item(afs_pkg::BYTE_ZERO, 1'b0);
			send_item(afs_pkg::BYTE_ZERO, 1'b0);
			send_item(8'($urandom_range(3, 2)), 1'b0);
		end else if (pick < 88) begin
			send_item(afs_pkg::BYTE_ZERO, 1'b0);
			send_item(afs_pkg::BYTE_ZERO, 1'b0);
			send_item(afs_pkg::BYTE_ONE, 1'b0);
		end else begin
			n = $urandom_range(4, 6);
			for (i = 0; i < n; i++)
				send_item(afs_pkg::BYTE_ZERO, 1'b0);
		end
	endtask

	initial begin
		int                         p;
		int                         start_items;
		logic [afs_pkg::TYPE_W-1:0] lo;
		logic [afs_pkg::TYPE_W-1:0] hi;
		sb             = new();
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		s_axis_tlast   = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = afs_pkg::CFG_MIN_TYPE;
		cfg_data       = '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_left      = 0;
		items_sent     = 0;
		cfg_writes     = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// closing unit of type 5: header and one payload byte
		send_item(8'h05, 1'b0);
		send_item(8'hFF, 1'b0);
		send_start_code();
		// zero header, fourth zero in a row, non-closing start code
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_start_code();
		// type 31, three zeros then 02, two zeros then 01
		send_item(8'h7F, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(8'h02, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(afs_pkg::BYTE_ONE, 1'b0);
		// end of input flushes held zeros, then an empty frame
		send_item(8'h80, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(afs_pkg::BYTE_ZERO, 1'b0);
		send_item(8'hAA, 1'b1);
		send_item(8'h55, 1'b1);
		drain_stream();

		for (p = 0; p < PHASES; p++) begin
			case (p)
				0: begin lo = afs_pkg::MIN_TYPE_RST; hi = afs_pkg::MAX_TYPE_RST; end
				1: begin lo = 5'd0;  hi = 5'd31; end
				2: begin lo = 5'd31; hi = 5'd0;  end
				3: begin lo = 5'd31; hi = 5'd31; end
				4: begin lo = 5'd0;  hi = 5'd0;  end
				default: begin lo = 5'($urandom); hi = 5'($urandom); end
			endcase
			write_reg(afs_pkg::CFG_MIN_TYPE, lo);
			write_reg(afs_pkg::CFG_MAX_TYPE, hi);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase
			start_items = items_sent;
			if (p == 2) begin
				send_item(8'h01, 1'b0);
				hold_left = HOLD_CYCLES;
			end
			while (items_sent - start_items < PHASE_ITEMS) begin
				send_unit();
				if (p == 1 && items_sent - start_items >= PHASE_ITEMS / 2
						&& items_sent - start_items < PHASE_ITEMS / 2 + 8) begin
					// sender waits for the splitter to run empty
					@(negedge clk);
					s_axis_tvalid = 1'b0;
					while (sb.pending() != 0)
						@(negedge clk);
				end
			end
			send_item(8'($urandom), 1'b1);
			drain_stream();
		end

		if (sb.pending() != 0)
			sb.report_mismatch("results never received", sb.pending(), 0);
		$display("covered %0d input bytes, %0d results, %0d frames, %0d register writes",
			items_sent, sb.results_seen, sb.frames_seen, cfg_writes);
		$display("type ranges included full, empty and single-type, idle patterns mixed");
		if (sb.errors == 0)
			$display("[annexb_frame_splitter] OK");
		else
			$display("[annexb_frame_splitter] ERROR");
		$finish;
	end

endmodule

[sim.f]
sv/afs_pkg.sv
sv/afs_front.sv
sv/afs_queue.sv
sv/afs_back.sv
sv/annexb_frame_splitter.sv
test/tb_annexb_frame_splitter.sv
